// ===== src/mrc_pkg.sv =====
package mrc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 20;
  localparam int unsigned LINE_BYTES_MIN = 11;

  // Only the leading bytes of a line are ever compared; the longest keyword sets this.
  localparam int unsigned KW_BYTES = 10;
  localparam int unsigned KW_BITS  = KW_BYTES * 8;
  localparam int unsigned KW_LEN_W = 4;

  localparam logic [7:0]  LINE_FEED       = 8'h0A;
  localparam logic [15:0] TIMEOUT_RST     = 16'd200;

  // Keywords, left-justified and zero padded to KW_BYTES.
  localparam logic [KW_BITS-1:0] KW_CONNECT    = {"CONNECT", 24'h0};
  localparam logic [KW_BITS-1:0] KW_RED        = {"RED", 56'h0};
  localparam logic [KW_BITS-1:0] KW_NO_CARRIER = "NO CARRIER";
  localparam logic [KW_BITS-1:0] KW_ERROR      = {"ERROR", 40'h0};
  localparam logic [KW_BITS-1:0] KW_OFA        = {"OFA", 56'h0};

  localparam logic [KW_LEN_W-1:0] LEN_CONNECT    = 4'd7;
  localparam logic [KW_LEN_W-1:0] LEN_RED        = 4'd3;
  localparam logic [KW_LEN_W-1:0] LEN_NO_CARRIER = 4'd10;
  localparam logic [KW_LEN_W-1:0] LEN_ERROR      = 4'd5;
  localparam logic [KW_LEN_W-1:0] LEN_OFA        = 4'd3;

  typedef enum logic [2:0] {
    ST_BOOT_SEL   = 3'd0,
    ST_CONNECT    = 3'd1,
    ST_RED        = 3'd2,
    ST_NO_CARRIER = 3'd3,
    ST_ERROR      = 3'd4,
    ST_OFA        = 3'd5,
    ST_TIMEOUT    = 3'd6
  } status_e;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tick;
    logic       boot_sel_level;
  } item_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } res_t;

endpackage

// ===== src/mrc_kw_match.sv =====
module mrc_kw_match import mrc_pkg::*; #(
  parameter int unsigned POS_W = 5
) (
  input  logic [KW_BYTES-1:0][7:0] store_i,
  input  logic [POS_W-1:0]         slot_i,
  output logic                     hit_o,
  output status_e                  code_o
);

  function automatic logic starts_with(input logic [KW_BYTES-1:0][7:0] s,
                                       input logic [KW_BITS-1:0] kw,
                                       input logic [KW_LEN_W-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < KW_BYTES; i++) begin
      if ((KW_LEN_W'(i) < len) && (s[i] != kw[KW_BITS-1-8*i -: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic m_connect, m_red, m_no_carrier, m_error, m_ofa;

  // keyword must fit entirely before the line feed slot
  assign m_connect    = (slot_i >= POS_W'(LEN_CONNECT)) &&
                        starts_with(store_i, KW_CONNECT, LEN_CONNECT);
  assign m_red        = (slot_i >= POS_W'(LEN_RED)) &&
                        starts_with(store_i, KW_RED, LEN_RED);
  assign m_no_carrier = (slot_i >= POS_W'(LEN_NO_CARRIER)) &&
                        starts_with(store_i, KW_NO_CARRIER, LEN_NO_CARRIER);
  assign m_error      = (slot_i >= POS_W'(LEN_ERROR)) &&
                        starts_with(store_i, KW_ERROR, LEN_ERROR);
  assign m_ofa        = (slot_i >= POS_W'(LEN_OFA)) &&
                        starts_with(store_i, KW_OFA, LEN_OFA);

  always_comb begin
    hit_o  = 1'b1;
    code_o = ST_CONNECT;
    if (m_connect) begin
      code_o = ST_CONNECT;
    end else if (m_red) begin
      code_o = ST_RED;
    end else if (m_no_carrier) begin
      code_o = ST_NO_CARRIER;
    end else if (m_error) begin
      code_o = ST_ERROR;
    end else if (m_ofa) begin
      code_o = ST_OFA;
    end else begin
      hit_o = 1'b0;
    end
  end

endmodule

// ===== src/mrc_core.sv =====
module mrc_core import mrc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  item_t       item_i,
  input  logic [15:0] timeout_i,
  output res_t        res_o
);

  localparam int unsigned POS_W = $clog2(LINE_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_BYTES - 1);

  logic                     armed_q, armed_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [15:0]              ticks_q, ticks_d;
  logic [KW_BYTES-1:0][7:0] store_q;
  logic                     store_wr;
  logic                     kw_hit;
  status_e                  kw_code;
  logic [15:0]              ticks_dec;
  logic                     reported;

  mrc_kw_match #(
    .POS_W (POS_W)
  ) u_kw_match (
    .store_i (store_q),
    .slot_i  (pos_q),
    .hit_o   (kw_hit),
    .code_o  (kw_code)
  );

  assign ticks_dec = (ticks_q != 16'd0) ? ticks_q - 16'd1 : 16'd0;

  always_comb begin
    armed_d      = armed_q;
    pos_d        = pos_q;
    ticks_d      = ticks_q;
    store_wr     = 1'b0;
    reported     = 1'b0;
    res_o.valid  = 1'b0;
    res_o.status = ST_BOOT_SEL;
    if (fire_i) begin
      if (item_i.operation == OP_START) begin
        ticks_d = (timeout_i == 16'd0) ? 16'd1 : timeout_i;
        pos_d   = '0;
        armed_d = 1'b1;
      end else if (armed_q) begin
        if (!item_i.boot_sel_level) begin
          armed_d      = 1'b0;
          res_o.valid  = 1'b1;
          res_o.status = ST_BOOT_SEL;
        end else begin
          if (item_i.rx_valid) begin
            store_wr = 1'b1;
            pos_d    = (pos_q == POS_LAST) ? pos_q : pos_q + POS_W'(1);
            if (item_i.rx_byte == LINE_FEED) begin
              if (kw_hit) begin
                armed_d      = 1'b0;
                reported     = 1'b1;
                res_o.valid  = 1'b1;
                res_o.status = kw_code;
              end else begin
                pos_d = '0;
              end
            end
          end
          // a line report swallows a tick in the same beat
          if (item_i.tick && !reported) begin
            ticks_d = ticks_dec;
            if (ticks_dec == 16'd0) begin
              armed_d      = 1'b0;
              res_o.valid  = 1'b1;
              res_o.status = ST_TIMEOUT;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      pos_q   <= '0;
      ticks_q <= '0;
    end else begin
      armed_q <= armed_d;
      pos_q   <= pos_d;
      ticks_q <= ticks_d;
    end
  end

  // slots past the longest keyword are never read, so they are not kept
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KW_BYTES; i++) begin
      if (store_wr && (pos_q == POS_W'(i))) begin
        store_q[i] <= item_i.rx_byte;
      end
    end
  end

endmodule

// ===== src/modem_reply_classifier_with_abort_core.sv =====
// Modem reply classifier. A start beat (operation 0) arms a wait and loads the timeout
// from the timeout_ticks register; each sample beat then checks boot-select (low aborts),
// stores any received byte into the current line and classifies the line on a line feed
// (CONNECT, RED, NO CARRIER, ERROR, OFA), and counts 50 ms ticks down to a timeout. One
// status beat comes out per report, after which the block is disarmed until the next start.
// Each beat is captured in an input register and resolved from there into the output
// register; one beat is taken every cycle while the output is being drained. Write
// timeout_ticks only while no beat is in flight.
module modem_reply_classifier_with_abort_core import mrc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic        rx_valid_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        tick_i,
  input  logic        boot_sel_level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  item_t       in_q;
  logic        in_valid_q;
  logic        out_valid_q;
  status_e     status_q;
  logic [15:0] timeout_q;
  logic        adv;
  logic        fire;
  res_t        res;

  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  mrc_core #(
    .LINE_BYTES (LINE_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= fire && res.valid;
      end
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.operation      <= op_e'(operation_i);
      in_q.rx_valid       <= rx_valid_i;
      in_q.rx_byte        <= rx_byte_i;
      in_q.tick           <= tick_i;
      in_q.boot_sel_level <= boot_sel_level_i;
    end
    if (fire && res.valid) begin
      status_q <= res.status;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

// ===== src/mrc_checker.sv =====
module mrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result beat dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 3'd7))
    else $error("undefined status code");

  // input only backs up behind a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared while input was stalled");

endmodule

bind modem_reply_classifier_with_abort_core mrc_checker u_mrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o)
);
